/* hdl/assert_macros.svh */
// assertion macros shared by the deadline timer table rtl
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* hdl/dtt_pkg.sv */
// types, codes and helpers of the deadline timer table
// no dependencies
package dtt_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int MAX_OUT   = 16;
  localparam int TIME_W    = 48;
  localparam int IVL_W     = 32;
  localparam int SLOT_W    = 4;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 2;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam logic [REQ_W-1:0] REQ_ADD     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CANCEL  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REFRESH = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RESET   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_QUERY   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_COLLECT = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_REFUSED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NONE    = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_EDIT, S_SCAN, S_PSCAN, S_PUPD, S_EMIT, S_LIST
  } ctl_state_e;

  typedef struct packed {
    logic latch;
    logic scan_start;
    logic scan_step;
    logic add_exec;
    logic cancel_exec;
    logic rd_slot;
    logic refresh_exec;
    logic reset_exec;
    logic front_eval;
    logic query_eval;
    logic bad_eval;
    logic none_eval;
    logic rd_best;
    logic pick_exec;
    logic emit_one;
    logic emit_list;
  } dtt_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic free_found;
    logic ok_slot;
    logic no_change;
    logic scan_done;
    logic found;
    logic pick_full;
    logic pick_empty;
    logic list_last;
    logic out_free;
  } dtt_sts_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] now,
                                                input logic [IVL_W-1:0] ivl);
    logic [TIME_W:0] s;
    s = {1'b0, now} + {{(TIME_W-IVL_W+1){1'b0}}, ivl};
    sat_add = s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

endpackage

/* hdl/deadline_timer_table_core.sv */
// a collect lists up to 16 due slots, one result per cycle while the output is not stalled
// throughput: one request at a time; each scan walks the deadline ram one slot per cycle
// reset: asynchronous active low, frees every slot and clears the front notice, no ram clearing
// top level of the deadline timer table; depends on dtt_pkg, dtt_ctrl, dtt_dp, dtt_ram
`include "assert_macros.svh"
module deadline_timer_table_core
  import dtt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // now_ms[47:0], slot[51:48], interval_ms[83:52], recurring[84], restart flag[85], zero fill
  input  logic [87:0] s_axis_tdata,
  // req_type[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // timer_slot[3:0], front flag[4], time_left[52:5], any_active[53], zero fill
  output logic [55:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  dtt_cmd_t          cmd;
  dtt_sts_t          sts;
  logic [SLOT_W-1:0] res_slot;
  logic              res_front, res_any;
  logic [TIME_W-1:0] res_left;

  // sequencer: accepts an item only when idle
  dtt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // slot state, scan unit and the output register
  dtt_dp #(.SLOTS(SLOTS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_i        (s_axis_tuser),
    .now_i        (s_axis_tdata[47:0]),
    .slot_i       (s_axis_tdata[51:48]),
    .ivl_i        (s_axis_tdata[83:52]),
    .rec_i        (s_axis_tdata[84]),
    .fnow_i       (s_axis_tdata[85]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_slot_o   (res_slot),
    .out_front_o  (res_front),
    .out_left_o   (res_left),
    .out_any_o    (res_any),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, res_any, res_left, res_front, res_slot};

  // an accepted item blocks the input until its results are produced
  `ASSERT_PROP(a_accept_blocks, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  // the result list of a collect is delivered without gaps
  `ASSERT_PROP(a_list_gapless, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
  // a front notice only comes with a successful arm
  `ASSERT_NEVER(a_front_ok, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[4] && (m_axis_tuser != ST_OK))

endmodule

/* hdl/dtt_ram.sv */
// generic single write port ram with registered read
// no dependencies
module dtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/dtt_dp.sv */
// datapath: slot state, deadline and interval rams, scan unit, pick list, result register
// depends on dtt_pkg and dtt_ram
module dtt_dp
  import dtt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dtt_cmd_t          cmd_i,
  output dtt_sts_t          sts_o,
  input  logic [REQ_W-1:0]  req_i,
  input  logic [TIME_W-1:0] now_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [IVL_W-1:0]  ivl_i,
  input  logic              rec_i,
  input  logic              fnow_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [STAT_W-1:0] out_status_o,
  output logic [SLOT_W-1:0] out_slot_o,
  output logic              out_front_o,
  output logic [TIME_W-1:0] out_left_o,
  output logic              out_any_o,
  output logic              out_last_o
);

  localparam int SW  = $clog2(SLOTS);
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int PCW = $clog2(MAX_OUT + 1);
  localparam int PIW = $clog2(MAX_OUT);

  // latched request
  logic [REQ_W-1:0]  req_q;
  logic [TIME_W-1:0] now_q;
  logic [SLOT_W-1:0] slot_q;
  logic [IVL_W-1:0]  ivl_q;
  logic              rec_q, fnow_q;

  logic [SLOTS-1:0]  active_q, picked_q;
  logic              fn_q;
  logic [SW-1:0]     pick_q [MAX_OUT];
  logic [PCW-1:0]    pcnt_q, eptr_q;
  logic [CW-1:0]     scan_cnt_q;
  logic              rd_vld_q, best_vld_q;
  logic [SW-1:0]     rd_idx_q, best_idx_q, tgt_q;
  logic [TIME_W-1:0] best_d_q;

  logic [STAT_W-1:0] res_st_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic              res_front_q;
  logic [TIME_W-1:0] res_tl_q;

  logic              out_vld_q, out_front_q, out_any_q, out_last_q;
  logic [STAT_W-1:0] out_st_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [TIME_W-1:0] out_tl_q;

  logic [SW-1:0]      slot_idx, free_idx, rd_addr, waddr;
  logic               free_found, ok_slot, no_change, cand, out_free, list_last;
  logic               dl_we, iv_we;
  logic [TIME_W-1:0]  dl_wd, dl_rd;
  logic [IVL_W:0]     iv_wd, iv_rd;

  assign slot_idx = SW'(slot_q);
  assign ok_slot  = (int'(slot_q) < SLOTS) && active_q[slot_idx];
  assign no_change = (ivl_q == iv_rd[IVL_W-1:0]) && !fnow_q;
  assign out_free  = !out_vld_q || out_ready_i;
  assign list_last = (eptr_q == pcnt_q - PCW'(1));

  // lowest free slot
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_idx   = SW'(i);
        free_found = 1'b1;
      end
    end
  end

  // candidate for the running minimum
  assign cand = rd_vld_q && active_q[rd_idx_q] &&
                ((req_q != REQ_COLLECT) || ((dl_rd <= now_q) && !picked_q[rd_idx_q]));

  always_comb begin
    if (cmd_i.rd_slot) begin
      rd_addr = slot_idx;
    end else if (cmd_i.rd_best) begin
      rd_addr = best_idx_q;
    end else begin
      rd_addr = scan_cnt_q[SW-1:0];
    end
  end

  always_comb begin
    dl_we = 1'b0;
    iv_we = 1'b0;
    waddr = free_idx;
    dl_wd = sat_add(now_q, ivl_q);
    iv_wd = {rec_q, ivl_q};
    if (cmd_i.add_exec && free_found) begin
      dl_we = 1'b1;
      iv_we = 1'b1;
    end
    if (cmd_i.refresh_exec && ok_slot) begin
      waddr = slot_idx;
      dl_we = 1'b1;
      dl_wd = sat_add(now_q, iv_rd[IVL_W-1:0]);
    end
    if (cmd_i.reset_exec && ok_slot && !no_change) begin
      waddr = slot_idx;
      iv_we = 1'b1;
      iv_wd = {iv_rd[IVL_W], ivl_q};
      dl_we = fnow_q;
    end
    if (cmd_i.pick_exec) begin
      waddr = best_idx_q;
      dl_we = iv_rd[IVL_W];
      dl_wd = sat_add(now_q, iv_rd[IVL_W-1:0]);
    end
  end

  dtt_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_dl_ram (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (waddr),
    .wdata_i (dl_wd),
    .raddr_i (rd_addr),
    .rdata_o (dl_rd)
  );

  // recurring mark rides in the top bit of the interval word
  dtt_ram #(.WIDTH(IVL_W + 1), .DEPTH(SLOTS)) u_iv_ram (
    .clk_i   (clk_i),
    .we_i    (iv_we),
    .waddr_i (waddr),
    .wdata_i (iv_wd),
    .raddr_i (rd_addr),
    .rdata_o (iv_rd)
  );

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q  <= req_i;
      now_q  <= now_i;
      slot_q <= slot_i;
      ivl_q  <= ivl_i;
      rec_q  <= rec_i;
      fnow_q <= fnow_i;
    end
    if (cmd_i.scan_step && scan_cnt_q != CW'(SLOTS)) begin
      rd_idx_q <= scan_cnt_q[SW-1:0];
    end
    if (cmd_i.scan_step && cand && (!best_vld_q || dl_rd < best_d_q)) begin
      best_idx_q <= rd_idx_q;
      best_d_q   <= dl_rd;
    end
    if (cmd_i.add_exec) begin
      tgt_q <= free_idx;
    end
    if (cmd_i.reset_exec) begin
      tgt_q <= slot_idx;
    end
    if (cmd_i.pick_exec) begin
      pick_q[pcnt_q[PIW-1:0]] <= best_idx_q;
    end
    if (cmd_i.latch) begin
      res_front_q <= 1'b0;
      res_tl_q    <= '0;
    end
    if (cmd_i.add_exec) begin
      res_st_q   <= free_found ? ST_OK : ST_FULL;
      res_slot_q <= free_found ? SLOT_W'(free_idx) : '0;
    end
    if (cmd_i.cancel_exec || cmd_i.refresh_exec) begin
      res_st_q   <= ok_slot ? ST_OK : ST_REFUSED;
      res_slot_q <= slot_q;
    end
    if (cmd_i.reset_exec) begin
      res_st_q   <= (ok_slot && !no_change) ? ST_OK : ST_REFUSED;
      res_slot_q <= slot_q;
    end
    if (cmd_i.front_eval) begin
      res_front_q <= best_vld_q && (best_idx_q == tgt_q) && !fn_q;
    end
    if (cmd_i.query_eval) begin
      res_slot_q <= '0;
      if (best_vld_q) begin
        res_st_q <= ST_OK;
        res_tl_q <= (best_d_q > now_q) ? best_d_q - now_q : '0;
      end else begin
        res_st_q <= ST_NONE;
        res_tl_q <= TIME_MAX;
      end
    end
    if (cmd_i.bad_eval) begin
      res_st_q   <= ST_REFUSED;
      res_slot_q <= '0;
    end
    if (cmd_i.none_eval) begin
      res_st_q   <= ST_NONE;
      res_slot_q <= '0;
    end
    if (cmd_i.emit_one) begin
      out_st_q    <= res_st_q;
      out_slot_q  <= res_slot_q;
      out_front_q <= res_front_q;
      out_tl_q    <= res_tl_q;
      out_any_q   <= |active_q;
      out_last_q  <= 1'b1;
    end
    if (cmd_i.emit_list) begin
      out_st_q    <= ST_OK;
      out_slot_q  <= SLOT_W'(pick_q[eptr_q[PIW-1:0]]);
      out_front_q <= 1'b0;
      out_tl_q    <= '0;
      out_any_q   <= |active_q;
      out_last_q  <= list_last;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= '0;
      picked_q   <= '0;
      fn_q       <= 1'b0;
      pcnt_q     <= '0;
      eptr_q     <= '0;
      scan_cnt_q <= '0;
      rd_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.latch) begin
        picked_q <= '0;
        pcnt_q   <= '0;
        eptr_q   <= '0;
      end
      if (cmd_i.scan_start) begin
        scan_cnt_q <= '0;
        rd_vld_q   <= 1'b0;
        best_vld_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        if (scan_cnt_q != CW'(SLOTS)) begin
          scan_cnt_q <= scan_cnt_q + CW'(1);
          rd_vld_q   <= 1'b1;
        end else begin
          rd_vld_q <= 1'b0;
        end
        if (cand && (!best_vld_q || dl_rd < best_d_q)) begin
          best_vld_q <= 1'b1;
        end
      end
      if (cmd_i.add_exec && free_found) begin
        active_q[free_idx] <= 1'b1;
      end
      if (cmd_i.cancel_exec && ok_slot) begin
        active_q[slot_idx] <= 1'b0;
      end
      if (cmd_i.front_eval && best_vld_q && (best_idx_q == tgt_q) && !fn_q) begin
        fn_q <= 1'b1;
      end
      if (cmd_i.query_eval) begin
        fn_q <= 1'b0;
      end
      if (cmd_i.pick_exec) begin
        if (!iv_rd[IVL_W]) begin
          active_q[best_idx_q] <= 1'b0;
        end
        picked_q[best_idx_q] <= 1'b1;
        pcnt_q <= pcnt_q + PCW'(1);
      end
      if (cmd_i.emit_list) begin
        eptr_q <= eptr_q + PCW'(1);
      end
      if (cmd_i.emit_one || cmd_i.emit_list) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.req        = req_q;
    sts_o.free_found = free_found;
    sts_o.ok_slot    = ok_slot;
    sts_o.no_change  = no_change;
    sts_o.scan_done  = (scan_cnt_q == CW'(SLOTS)) && !rd_vld_q;
    sts_o.found      = best_vld_q;
    sts_o.pick_full  = (pcnt_q == PCW'(MAX_OUT - 1));
    sts_o.pick_empty = (pcnt_q == '0);
    sts_o.list_last  = list_last;
    sts_o.out_free   = out_free;
  end

  assign out_valid_o  = out_vld_q;
  assign out_status_o = out_st_q;
  assign out_slot_o   = out_slot_q;
  assign out_front_o  = out_front_q;
  assign out_left_o   = out_tl_q;
  assign out_any_o    = out_any_q;
  assign out_last_o   = out_last_q;

endmodule

/* hdl/dtt_ctrl.sv */
// controller state machine sequencing requests over the datapath
// depends on dtt_pkg
module dtt_ctrl
  import dtt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dtt_sts_t sts_i,
  output dtt_cmd_t cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISP;
      end
      S_DISP: begin
        case (sts_i.req)
          REQ_ADD:                state_d = sts_i.free_found ? S_SCAN : S_EMIT;
          REQ_REFRESH, REQ_RESET: state_d = S_EDIT;
          REQ_QUERY:              state_d = S_SCAN;
          REQ_COLLECT:            state_d = S_PSCAN;
          default:                state_d = S_EMIT;
        endcase
      end
      S_EDIT: begin
        if (sts_i.req == REQ_RESET && sts_i.ok_slot && !sts_i.no_change) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) state_d = S_EMIT;
      end
      S_PSCAN: begin
        if (sts_i.scan_done) begin
          if (sts_i.found) state_d = S_PUPD;
          else if (sts_i.pick_empty) state_d = S_EMIT;
          else state_d = S_LIST;
        end
      end
      S_PUPD: begin
        state_d = sts_i.pick_full ? S_LIST : S_PSCAN;
      end
      S_EMIT: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      S_LIST: begin
        if (sts_i.out_free && sts_i.list_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      S_DISP: begin
        case (sts_i.req)
          REQ_ADD: begin
            cmd_o.add_exec   = 1'b1;
            cmd_o.scan_start = sts_i.free_found;
          end
          REQ_CANCEL:             cmd_o.cancel_exec = 1'b1;
          REQ_REFRESH, REQ_RESET: cmd_o.rd_slot = 1'b1;
          REQ_QUERY, REQ_COLLECT: cmd_o.scan_start = 1'b1;
          default:                cmd_o.bad_eval = 1'b1;
        endcase
      end
      S_EDIT: begin
        if (sts_i.req == REQ_REFRESH) begin
          cmd_o.refresh_exec = 1'b1;
        end else begin
          cmd_o.reset_exec = 1'b1;
          cmd_o.scan_start = sts_i.ok_slot && !sts_i.no_change;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          if (sts_i.req == REQ_QUERY) cmd_o.query_eval = 1'b1;
          else cmd_o.front_eval = 1'b1;
        end
      end
      S_PSCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          cmd_o.rd_best   = sts_i.found;
          cmd_o.none_eval = !sts_i.found && sts_i.pick_empty;
        end
      end
      S_PUPD: begin
        cmd_o.pick_exec  = 1'b1;
        cmd_o.scan_start = !sts_i.pick_full;
      end
      S_EMIT:  cmd_o.emit_one = sts_i.out_free;
      S_LIST:  cmd_o.emit_list = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule
